FILE: hdl/mrhr_pkg.sv
`default_nettype none
package mrhr_pkg;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REV      = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] MAX_COUNT         = 16'h007D;
  localparam logic [7:0]  EXC_FLAG          = 8'h80;
  localparam logic [7:0]  EXC_NONE          = 8'h00;
  localparam logic [7:0]  EXC_ILLEGAL_FUNC  = 8'h01;
  localparam logic [7:0]  EXC_ILLEGAL_ADDR  = 8'h02;
  localparam logic [7:0]  EXC_ILLEGAL_VALUE = 8'h03;

  // control of the shared CRC unit
  typedef struct packed {
    logic       init;   // reload the seed
    logic       start;  // xor in a byte and run eight bit steps
    logic [7:0] data;
  } crc_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/mrhr_crc_unit.sv
`default_nettype none
module mrhr_crc_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mrhr_pkg::crc_ctl_t ctl,
  output logic [15:0]            crc,
  output logic                   busy
);

  logic [3:0] steps;

  assign busy = (steps != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= mrhr_pkg::CRC_INIT;
      steps <= 4'd0;
    end else if (ctl.init) begin
      crc   <= mrhr_pkg::CRC_INIT;
      steps <= 4'd0;
    end else if (ctl.start) begin
      crc   <= crc ^ {8'h00, ctl.data};
      steps <= 4'd8;
    end else if (busy) begin
      // one reflected bit step per cycle
      crc   <= crc[0] ? ((crc >> 1) ^ mrhr_pkg::CRC_POLY_REV) : (crc >> 1);
      steps <= steps - 4'd1;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mrhr_regmap.sv
`default_nettype none
module mrhr_regmap #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [15:0]        rdata,
  output logic               busy
);

  logic [15:0] mem [DEPTH];
  logic [AW:0] clr_cnt;

  assign busy = (clr_cnt < (AW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // clear sweep after reset, then host writes
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt[AW-1:0]] <= 16'h0000;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hdl/modbus_rtu_holding_register_slave_top.sv
`default_nettype none
// Modbus RTU slave answering read holding registers (function 03).
// Input channel (in_valid/in_ready): with mode 0 a beat carries one request
// byte, end_of_frame marks the last one; with mode 1 a beat writes reg_value
// into the map at reg_index (ignored beyond MAP_DEPTH).
// Config channel (cfg_valid/cfg_ready): cfg_data sets the slave address.
// Output channel (out_valid/out_ready): response beats of up to four bytes,
// first byte in tx_bytes[7:0], byte_count valid bytes, last on the CRC beat.
// Timing: each request byte runs through the bit-serial CRC unit (8 steps a
// byte) and the sequencer waits in S_RXWAIT until it is done. After the final
// byte a response is built with the same CRC unit walking every byte; a
// dropped frame returns to idle from S_JUDGE. No input is taken meanwhile.
// Reset: a clearing pass zeroes every map entry with in_ready low; config
// writes are taken throughout.
// Stall: a full output register holds the sequencer until out_ready; input
// is taken again once the last beat is loaded into the output register.
module modbus_rtu_holding_register_slave_top #(
  parameter int MAP_DEPTH = 512,
  parameter int MAX_FRAME = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        end_of_frame,
  input  wire logic [8:0]  reg_index,
  input  wire logic [15:0] reg_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      tx_bytes,
  output logic [2:0]       byte_count,
  output logic             last
);

  localparam int AW  = $clog2(MAP_DEPTH);
  localparam int FLW = $clog2(MAX_FRAME + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RXWAIT = 7'b0000010,
    S_JUDGE  = 7'b0000100,
    S_FETCH  = 7'b0001000,
    S_FEED   = 7'b0010000,
    S_WAIT   = 7'b0100000,
    S_PUSH   = 7'b1000000
  } state_t;

  state_t state;

  logic [7:0]     slave_address;
  logic [FLW-1:0] frame_length;
  logic [7:0]     header [6];
  logic [7:0]     tail [2];
  logic           eof_q;

  logic [7:0]  fc_q;
  logic [15:0] start_q;
  logic [15:0] count_q;
  logic [7:0]  exc_q;
  logic [8:0]  data_end;
  logic [8:0]  bidx;
  logic [7:0]  pack [4];
  logic [2:0]  pcnt;

  mrhr_pkg::crc_ctl_t crc_ctl;
  logic [15:0] crc;
  logic        crc_busy;

  logic          map_we;
  logic [AW-1:0] map_raddr;
  logic [15:0]   map_rdata;
  logic          map_busy;

  logic in_fire, out_load, push_last, frame_ok;
  logic [7:0] cur_byte, exc_code;
  logic [8:0] k;
  logic [16:0] end_addr;

  mrhr_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .crc  (crc),
    .busy (crc_busy)
  );

  mrhr_regmap #(.DEPTH(MAP_DEPTH), .AW(AW)) u_map (
    .clk   (clk),
    .rst   (rst),
    .we    (map_we),
    .waddr (AW'(reg_index)),
    .wdata (reg_value),
    .raddr (map_raddr),
    .rdata (map_rdata),
    .busy  (map_busy)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !map_busy;
  assign in_fire   = in_valid && in_ready;
  assign map_we    = in_fire && mode && (17'(reg_index) < 17'(MAP_DEPTH));

  assign out_load  = (state == S_PUSH) && (!out_valid || out_ready);
  assign push_last = (bidx == data_end + 9'd1);

  // frame check on the accumulated state
  assign frame_ok = (frame_length >= FLW'(2)) && (header[0] == slave_address) &&
                    (tail[1] == crc[15:8]) && (tail[0] == crc[7:0]);
  assign end_addr = {1'b0, header[2], header[3]} + {1'b0, header[4], header[5]};

  always_comb begin
    priority if (header[1] != mrhr_pkg::FUNC_READ_HOLDING) begin
      exc_code = mrhr_pkg::EXC_ILLEGAL_FUNC;
    end else if (({header[4], header[5]} == 16'h0000) ||
                 ({header[4], header[5]} > mrhr_pkg::MAX_COUNT)) begin
      exc_code = mrhr_pkg::EXC_ILLEGAL_VALUE;
    end else if (end_addr > 17'(MAP_DEPTH)) begin
      exc_code = mrhr_pkg::EXC_ILLEGAL_ADDR;
    end else begin
      exc_code = mrhr_pkg::EXC_NONE;
    end
  end

  // response byte at position bidx
  assign k = bidx - 9'd3;
  assign map_raddr = AW'({1'b0, start_q} + 17'(k[8:1]));

  always_comb begin
    priority if (bidx == 9'd0) begin
      cur_byte = slave_address;
    end else if (bidx == 9'd1) begin
      cur_byte = (exc_q != mrhr_pkg::EXC_NONE) ? (fc_q + mrhr_pkg::EXC_FLAG) : fc_q;
    end else if (bidx == 9'd2) begin
      cur_byte = (exc_q != mrhr_pkg::EXC_NONE) ? exc_q : {count_q[6:0], 1'b0};
    end else if (bidx == data_end) begin
      cur_byte = crc[7:0];
    end else if (bidx > data_end) begin
      cur_byte = crc[15:8];
    end else begin
      cur_byte = k[0] ? map_rdata[7:0] : map_rdata[15:8];
    end
  end

  always_comb begin
    crc_ctl = '0;
    crc_ctl.data = cur_byte;
    unique case (state)
      S_IDLE: begin
        // feed the byte leaving the tail delay
        if (in_fire && !mode && (frame_length < FLW'(MAX_FRAME)) &&
            (frame_length >= FLW'(2))) begin
          crc_ctl.start = 1'b1;
          crc_ctl.data  = tail[0];
        end
      end
      S_JUDGE: crc_ctl.init = 1'b1;
      S_FEED:  crc_ctl.start = (bidx < data_end);
      S_PUSH:  crc_ctl.init = out_load && push_last;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      slave_address <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_length <= '0;
      header       <= '{default: 8'h00};
      tail         <= '{default: 8'h00};
      pack         <= '{default: 8'h00};
      pcnt         <= 3'd0;
      bidx         <= 9'd0;
      eof_q        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire && !mode) begin
            if (frame_length < FLW'(MAX_FRAME)) begin
              tail[0] <= tail[1];
              tail[1] <= rx_byte;
              if (frame_length < FLW'(6)) begin
                header[frame_length[2:0]] <= rx_byte;
              end
              frame_length <= frame_length + 1'b1;
            end
            eof_q <= end_of_frame;
            state <= S_RXWAIT;
          end
        end
        S_RXWAIT: begin
          if (!crc_busy) begin
            state <= eof_q ? S_JUDGE : S_IDLE;
          end
        end
        S_JUDGE: begin
          fc_q     <= header[1];
          start_q  <= {header[2], header[3]};
          count_q  <= {header[4], header[5]};
          exc_q    <= exc_code;
          data_end <= (exc_code != mrhr_pkg::EXC_NONE) ? 9'd3 :
                      9'd3 + {header[5], 1'b0};
          bidx     <= 9'd0;
          pcnt     <= 3'd0;
          // drop the frame state whatever the verdict
          frame_length <= '0;
          header       <= '{default: 8'h00};
          tail         <= '{default: 8'h00};
          state        <= frame_ok ? S_FETCH : S_IDLE;
        end
        S_FETCH: state <= S_FEED;
        S_FEED: begin
          pack[pcnt[1:0]] <= cur_byte;
          pcnt            <= pcnt + 3'd1;
          state           <= S_WAIT;
        end
        S_WAIT: begin
          if (!crc_busy) begin
            if ((pcnt == 3'd4) || push_last) begin
              state <= S_PUSH;
            end else begin
              bidx  <= bidx + 9'd1;
              state <= S_FETCH;
            end
          end
        end
        S_PUSH: begin
          if (out_load) begin
            pack  <= '{default: 8'h00};
            pcnt  <= 3'd0;
            if (push_last) begin
              state <= S_IDLE;
            end else begin
              bidx  <= bidx + 9'd1;
              state <= S_FETCH;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tx_bytes   <= {pack[3], pack[2], pack[1], pack[0]};
      byte_count <= pcnt;
      last       <= push_last;
    end
  end

  a_judge_crc_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_JUDGE) |-> !crc_busy)
    else $error("frame judged while CRC still running");

  a_pack_bound: assert property (@(posedge clk) disable iff (rst)
    pcnt <= 3'd4)
    else $error("pack count overran");

  a_ready_after_clear: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !map_busy)
    else $error("input taken during map clear");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && push_last) |=> (state == S_IDLE) && out_valid && last)
    else $error("final beat did not end the response");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 3'd0) && (byte_count <= 3'd4))
    else $error("output beat with bad byte count");

endmodule
`default_nettype wire

FILE: test/modbus_rtu_holding_register_slave_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module modbus_rtu_holding_register_slave_top_tb;

  localparam int MAP_DEPTH = 512;
  localparam int MAX_FRAME = 256;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [31:0] bytes;
    logic [2:0]  count;
    logic        is_last;
  } tx_beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [7:0]  rx_byte;
  logic        end_of_frame;
  logic [8:0]  reg_index;
  logic [15:0] reg_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] tx_bytes;
  logic [2:0]  byte_count;
  logic        last;

  // predictor state, mirrored from the block's behavior
  logic [7:0]  own_addr;
  logic [15:0] holding_map [MAP_DEPTH];
  logic [15:0] rx_crc;
  int          rx_len;
  logic [7:0]  hdr [6];
  logic [7:0]  crc_tail [2];

  tx_beat_t    resp_queue [$];
  int          mismatches;
  int          cycles;
  bit          hold_off;
  int          hold_cycles;

  modbus_rtu_holding_register_slave_top #(
    .MAP_DEPTH(MAP_DEPTH),
    .MAX_FRAME(MAX_FRAME)
  ) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .rx_byte(rx_byte), .end_of_frame(end_of_frame),
    .reg_index(reg_index), .reg_value(reg_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .tx_bytes(tx_bytes), .byte_count(byte_count), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort on a hung run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ mrhr_pkg::CRC_POLY_REV) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_frame();
    rx_crc = mrhr_pkg::CRC_INIT;
    rx_len = 0;
    foreach (hdr[i]) hdr[i] = 8'h00;
    crc_tail[0] = 8'h00;
    crc_tail[1] = 8'h00;
  endfunction

  // Append CRC to a response and cut it into beats of up to four bytes.
  function automatic void queue_response(logic [7:0] buf_in[$]);
    logic [15:0] crc;
    logic [7:0]  b [$];
    tx_beat_t    beat;
    int          cnt;
    b = buf_in;
    crc = mrhr_pkg::CRC_INIT;
    foreach (b[i]) crc = crc16_step(crc, b[i]);
    b.push_back(crc[7:0]);
    b.push_back(crc[15:8]);
    for (int i = 0; i < b.size(); i += 4) begin
      cnt = (b.size() - i) < 4 ? (b.size() - i) : 4;
      beat.bytes = '0;
      for (int j = 0; j < cnt; j++) beat.bytes[8*j +: 8] = b[i+j];
      beat.count = cnt[2:0];
      beat.is_last = (i + cnt >= b.size());
      resp_queue.push_back(beat);
    end
  endfunction

  // Judge a finished frame and queue the reply, if any.
  function automatic void judge_request();
    logic [7:0]  rsp [$];
    logic [7:0]  fc;
    int          first;
    int          cnt;
    logic [15:0] w;
    if (rx_len < 2 || hdr[0] != own_addr) return;
    if (crc_tail[1] != rx_crc[15:8] || crc_tail[0] != rx_crc[7:0]) return;
    fc = hdr[1];
    first = {hdr[2], hdr[3]};
    cnt = {hdr[4], hdr[5]};
    rsp.push_back(own_addr);
    if (fc != mrhr_pkg::FUNC_READ_HOLDING || cnt < 1 || cnt > mrhr_pkg::MAX_COUNT ||
        first + cnt > MAP_DEPTH) begin
      rsp.push_back(8'(fc + mrhr_pkg::EXC_FLAG));
      if (fc != mrhr_pkg::FUNC_READ_HOLDING) rsp.push_back(mrhr_pkg::EXC_ILLEGAL_FUNC);
      else if (cnt < 1 || cnt > mrhr_pkg::MAX_COUNT) rsp.push_back(mrhr_pkg::EXC_ILLEGAL_VALUE);
      else rsp.push_back(mrhr_pkg::EXC_ILLEGAL_ADDR);
    end else begin
      rsp.push_back(fc);
      rsp.push_back(8'(cnt * 2));
      for (int i = 0; i < cnt; i++) begin
        w = holding_map[first + i];
        rsp.push_back(w[15:8]);
        rsp.push_back(w[7:0]);
      end
    end
    queue_response(rsp);
  endfunction

  function automatic void predict_beat(logic m, logic [7:0] b, logic eof, logic [8:0] idx,
                                       logic [15:0] val);
    if (m) begin
      if (idx < MAP_DEPTH) holding_map[idx] = val;
      return;
    end
    if (rx_len < MAX_FRAME) begin
      if (rx_len >= 2) rx_crc = crc16_step(rx_crc, crc_tail[0]);
      crc_tail[0] = crc_tail[1];
      crc_tail[1] = b;
      if (rx_len < 6) hdr[rx_len] = b;
      rx_len++;
    end
    if (eof) begin
      judge_request();
      clear_frame();
    end
  endfunction

  // Send one beat; random gaps come from a burst counter.
  int burst_left;
  task automatic send_beat(logic m, logic [7:0] b, logic eof, logic [8:0] idx, logic [15:0] val);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= m;
    rx_byte <= b;
    end_of_frame <= eof;
    reg_index <= idx;
    reg_value <= val;
    predict_beat(m, b, eof, idx, val);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic host_write(int idx, logic [15:0] val);
    send_beat(1'b1, 8'($urandom), 1'($urandom), idx[8:0], val);
  endtask

  // Send a whole request with a CRC appended, correct unless good_crc is cleared.
  task automatic send_frame(logic [7:0] body[$], bit good_crc = 1);
    logic [15:0] crc;
    crc = mrhr_pkg::CRC_INIT;
    foreach (body[i]) crc = crc16_step(crc, body[i]);
    if (!good_crc) crc ^= 16'h0001 << $urandom_range(0, 15);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    foreach (body[i])
      send_beat(1'b0, body[i], i == body.size() - 1, 9'($urandom), 16'($urandom));
  endtask

  task automatic read_request(logic [7:0] adr, logic [7:0] fc, int first, int cnt,
                              bit good_crc = 1);
    logic [7:0] q [$];
    q = {adr, fc, 8'(first >> 8), 8'(first), 8'(cnt >> 8), 8'(cnt)};
    send_frame(q, good_crc);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (resp_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_address(logic [7:0] a);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    own_addr = a;
  endtask

  // Check each beat leaving the block against the oldest expectation.
  always @(posedge clk) begin
    tx_beat_t exp_beat;
    if (!rst && out_valid && out_ready) begin
      if (resp_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat bytes=%h count=%0d last=%b", tx_bytes, byte_count, last);
      end else begin
        exp_beat = resp_queue.pop_front();
        if (tx_bytes !== exp_beat.bytes || byte_count !== exp_beat.count ||
            last !== exp_beat.is_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: exp %h/%0d/%b got %h/%0d/%b", exp_beat.bytes,
                     exp_beat.count, exp_beat.is_last, tx_bytes, byte_count, last);
        end
      end
    end
  end

  // Receiver stall pattern, overridden by a long hold-off.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= (cycles % 64 < 40) ? 1'b1 : ($urandom_range(0, 2) == 0);
  end

  initial begin
    hold_off = 0;
    wait (hold_cycles > 0);
    hold_off = 1;
    repeat (hold_cycles) @(posedge clk);
    hold_off = 0;
  end

  task automatic test_directed();
    host_write(0, 16'hFFFF);
    host_write(511, 16'hA55A);
    host_write(5, 16'h1234);
    host_write(511 + 0, 16'h8001);
    read_request(8'h01, mrhr_pkg::FUNC_READ_HOLDING, 0, 1);
    read_request(8'h01, mrhr_pkg::FUNC_READ_HOLDING, 511, 1);
    read_request(8'h01, mrhr_pkg::FUNC_READ_HOLDING, 0, 125);
    read_request(8'h01, 8'h10, 0, 1);
    read_request(8'h01, 8'hFF, 0, 1);
    read_request(8'h01, mrhr_pkg::FUNC_READ_HOLDING, 0, 0);
    read_request(8'h01, mrhr_pkg::FUNC_READ_HOLDING, 0, 126);
    read_request(8'h01, mrhr_pkg::FUNC_READ_HOLDING, 500, 20);
    read_request(8'h01, mrhr_pkg::FUNC_READ_HOLDING, 16'hFFFF, 16'hFFFF);
    read_request(8'h02, mrhr_pkg::FUNC_READ_HOLDING, 0, 1);
    read_request(8'h01, mrhr_pkg::FUNC_READ_HOLDING, 0, 1, 0);
    send_beat(1'b0, 8'h01, 1'b1, 0, 0);
  endtask

  task automatic test_short_frames();
    // A tiny frame where the CRC bytes double as header bytes.
    for (int n = 2; n <= 5; n++) begin
      logic [7:0] q [$];
      q = {own_addr};
      for (int i = 1; i < n - 2; i++) q.push_back(8'($urandom));
      if (n >= 3) send_frame(q);
      else send_beat(1'b0, own_addr, 1'b0, 0, 0);
      if (n < 3) send_beat(1'b0, 8'($urandom), 1'b1, 0, 0);
    end
  endtask

  task automatic test_overlong_frame();
    for (int i = 0; i < MAX_FRAME + 6; i++)
      send_beat(1'b0, i == 0 ? own_addr : 8'($urandom), i == MAX_FRAME + 5, 0, 0);
  endtask

  task automatic test_random(int n_items);
    int sent;
    int k;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(0, 9);
      if (k < 3) begin
        host_write($urandom_range(0, 511), 16'($urandom));
        sent++;
      end else if (k < 8) begin
        read_request($urandom_range(0, 7) == 0 ? 8'($urandom) : own_addr,
                     $urandom_range(0, 5) == 0 ? 8'($urandom) : mrhr_pkg::FUNC_READ_HOLDING,
                     $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 520),
                     $urandom_range(0, 4) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 12),
                     $urandom_range(0, 9) != 0);
        sent += 8;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_beat(1'b0, 8'($urandom), 1'b0, 0, 0);
          sent++;
        end
        send_beat(1'b0, 8'($urandom), 1'b1, 0, 0);
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    repeat (6) read_request(own_addr, mrhr_pkg::FUNC_READ_HOLDING, $urandom_range(0, 400), 30);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; mode = 1'b0; rx_byte = '0; end_of_frame = 1'b0;
    reg_index = '0; reg_value = '0;
    cfg_valid = 1'b0; cfg_data = '0;
    mismatches = 0; burst_left = 0; hold_cycles = 0;
    own_addr = 8'd1;
    foreach (holding_map[i]) holding_map[i] = 16'h0000;
    clear_frame();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_short_frames();
    test_overlong_frame();
    write_address(8'h00);
    test_short_frames();
    write_address(8'hFF);
    test_short_frames();
    test_random(10);
    test_backpressure();
    write_address(8'($urandom_range(2, 254)));
    test_random(10);

    drain();
    if (mismatches == 0 && resp_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: modbus_rtu_holding_register_slave_top.f
hdl/mrhr_pkg.sv
hdl/mrhr_crc_unit.sv
hdl/mrhr_regmap.sv
hdl/modbus_rtu_holding_register_slave_top.sv
test/modbus_rtu_holding_register_slave_top_tb.sv
